[rtl/psa_pkg.sv]
// Shared types and constants for the pooled slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_POOLS_DEF      = 32;
    localparam int SLOTS_PER_POOL_DEF = 32;

    // Fixed field widths
    localparam int ID_W   = 16;
    localparam int TAG_W  = 16;
    localparam int IDX_W  = 5;   // width of pool_index and slot_index results
    localparam int CNT_W  = 6;   // per-pool use count

    // Request payload
    typedef struct packed {
        logic [ID_W-1:0]         owner_id;
        logic signed [TAG_W-1:0] tag;
    } t_req;

    // Response payload
    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] pool_index;
        logic [IDX_W-1:0] slot_index;
    } t_rsp;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic [ID_W-1:0]         owner_id;
        logic signed [TAG_W-1:0] tag;
        logic                    m_hit;   // first owner/tag match seen
        logic                    m_ok;    // that pool had a free slot
        logic [IDX_W-1:0]        m_pool;
        logic [IDX_W-1:0]        m_slot;
        logic                    c_hit;   // first empty pool seen
        logic                    c_ok;
        logic [IDX_W-1:0]        c_pool;
        logic [IDX_W-1:0]        c_slot;
    } t_token;

    // Write-back broadcast to all cells
    typedef struct packed {
        logic                    en_match;
        logic                    en_claim;
        logic [IDX_W-1:0]        slot;
        logic [ID_W-1:0]         owner_id;
        logic signed [TAG_W-1:0] tag;
    } t_commit;

endpackage

`default_nettype wire

[rtl/psa_cell.sv]
// One pool cell: holds a pool's state and updates the search token in passing.
`timescale 1ns / 1ps
`default_nettype none

module psa_cell
    import psa_pkg::*;
#(
    parameter int SLOTS_PER_POOL = SLOTS_PER_POOL_DEF,
    parameter int POOL_ID        = 0,
    parameter bit CAN_CLAIM      = 1'b1
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_token  i_tok,
    output t_token       o_tok,
    input  wire t_commit i_commit
);

    localparam logic [IDX_W-1:0] POOL_TAG_ID = IDX_W'(POOL_ID % 32);

    // Pool state
    logic [SLOTS_PER_POOL-1:0] r_occ;
    logic [CNT_W-1:0]          r_count;
    logic [TAG_W-1:0]          r_tag;
    logic [ID_W-1:0]           r_owner;
    logic                      r_sel_match;
    logic                      r_sel_claim;
    t_token                    r_tok;

    logic                      free_found;
    logic [IDX_W-1:0]          free_slot;
    logic                      match_cond;
    logic                      claim_cond;
    logic                      set_m;
    logic                      set_c;
    logic                      wr;
    t_token                    n_tok;
    logic [SLOTS_PER_POOL-1:0] n_occ;

    // Lowest free slot of this pool
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOTS_PER_POOL - 1; s >= 0; s--) begin
            if (!r_occ[s]) begin
                free_found = 1'b1;
                free_slot  = IDX_W'(s);
            end
        end
    end

    // Token update: first match and first empty pool win
    always_comb begin
        match_cond = (r_owner == i_tok.owner_id) && (r_tag == i_tok.tag) &&
                     (r_count < CNT_W'(SLOTS_PER_POOL));
        claim_cond = CAN_CLAIM && (r_count == '0);
        set_m      = i_tok.valid && !i_tok.m_hit && match_cond;
        set_c      = i_tok.valid && !i_tok.c_hit && claim_cond;
        n_tok      = i_tok;
        if (set_m) begin
            n_tok.m_hit  = 1'b1;
            n_tok.m_ok   = free_found;
            n_tok.m_pool = POOL_TAG_ID;
            n_tok.m_slot = free_slot;
        end
        if (set_c) begin
            n_tok.c_hit  = 1'b1;
            n_tok.c_ok   = free_found;
            n_tok.c_pool = POOL_TAG_ID;
            n_tok.c_slot = free_slot;
        end
    end

    // Write-back decode
    always_comb begin
        wr    = (i_commit.en_match && r_sel_match) || (i_commit.en_claim && r_sel_claim);
        n_occ = r_occ;
        for (int s = 0; s < SLOTS_PER_POOL; s++) begin
            if (i_commit.slot == IDX_W'(s)) begin
                n_occ[s] = 1'b1;
            end
        end
    end

    // Pool state and token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_count     <= '0;
            r_tag       <= '0;
            r_owner     <= '0;
            r_sel_match <= 1'b0;
            r_sel_claim <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_sel_match <= set_m;
                r_sel_claim <= set_c;
            end
            if (wr) begin
                r_occ   <= n_occ;
                r_count <= r_count + CNT_W'(1);
                if (i_commit.en_claim) begin
                    r_tag   <= i_commit.tag;
                    r_owner <= i_commit.owner_id;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[rtl/pooled_slot_allocator.sv]
// Top level of the pooled slot allocator: request entry, cell chain and result stage.
//
//  channel  | valid    | ready    | payload        | dir
//  ---------+----------+----------+----------------+-----
//  request  | i_valid  | o_ready  | i_req (t_req)  | in
//  response | o_valid  | i_ready  | o_rsp (t_rsp)  | out
//
// A request enters the chain of NUM_POOLS cells and moves one cell per cycle.
// The next request is taken once the previous one has written back, even
// while its response still waits on o_valid.
// A stalled response holds the write-back until the output register frees.
// Synchronous active-low reset clears every pool's state.
`timescale 1ns / 1ps
`default_nettype none

module pooled_slot_allocator
    import psa_pkg::*;
#(
    parameter int NUM_POOLS      = NUM_POOLS_DEF,
    parameter int SLOTS_PER_POOL = SLOTS_PER_POOL_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_rsp      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state  r_state;
    logic    r_ready;
    logic    r_out_valid;
    t_rsp    r_rsp;
    t_rsp    r_dec_rsp;
    t_commit r_dec_commit;

    t_token                 w_tok [NUM_POOLS+1];
    logic [NUM_POOLS-1:0]   w_tok_valid;
    logic                   in_xfer;
    logic                   fire;
    t_commit                w_commit;
    t_token                 exit_tok;
    t_rsp                   n_rsp;
    t_commit                n_commit;

    assign in_xfer = i_valid && r_ready;

    // Entry token
    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].valid    = in_xfer;
        w_tok[0].owner_id = i_req.owner_id;
        w_tok[0].tag      = i_req.tag;
    end

    // Cell chain
    for (genvar g = 0; g < NUM_POOLS; g++) begin : g_cell
        psa_cell #(
            .SLOTS_PER_POOL (SLOTS_PER_POOL),
            .POOL_ID        (g),
            .CAN_CLAIM      (g < NUM_POOLS - 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1]),
            .i_commit (w_commit)
        );
        assign w_tok_valid[g] = w_tok[g+1].valid;
    end

    // Decision on the token leaving the last cell
    always_comb begin
        exit_tok          = w_tok[NUM_POOLS];
        n_rsp             = '0;
        n_commit          = '0;
        n_commit.owner_id = exit_tok.owner_id;
        n_commit.tag      = exit_tok.tag;
        if (exit_tok.m_hit && exit_tok.m_ok) begin
            n_rsp.granted      = 1'b1;
            n_rsp.pool_index   = exit_tok.m_pool;
            n_rsp.slot_index   = exit_tok.m_slot;
            n_commit.en_match  = 1'b1;
            n_commit.slot      = exit_tok.m_slot;
        end else if (exit_tok.c_hit && exit_tok.c_ok) begin
            n_rsp.granted      = 1'b1;
            n_rsp.pool_index   = exit_tok.c_pool;
            n_rsp.slot_index   = exit_tok.c_slot;
            n_commit.en_claim  = 1'b1;
            n_commit.slot      = exit_tok.c_slot;
        end
    end

    // Write-back goes out together with the response load
    assign fire = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        w_commit          = r_dec_commit;
        w_commit.en_match = r_dec_commit.en_match && fire;
        w_commit.en_claim = r_dec_commit.en_claim && fire;
    end

    // Control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_SCAN;
                        r_ready <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (exit_tok.valid) begin
                        r_dec_rsp    <= n_rsp;
                        r_dec_commit <= n_commit;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (fire) begin
                        r_rsp       <= r_dec_rsp;
                        r_out_valid <= 1'b1;
                        r_ready     <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_ready = r_ready;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    // Only one request walks the chain at a time
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one token in the cell chain");

    // The token leaves the chain only while scanning
    a_exit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exit_tok.valid |-> (r_state == S_SCAN))
        else $error("token left the chain outside a scan");

    // A failed request reports pool and slot zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.granted) |-> (o_rsp.pool_index == '0 && o_rsp.slot_index == '0))
        else $error("failed response carries nonzero indices");

    // Requests are taken only with no search in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (w_tok_valid == '0 && r_state == S_IDLE))
        else $error("ready while a request is in flight");
`endif

endmodule

`default_nettype wire

[sim/pooled_slot_allocator_chk.sv]
// Checker for the pooled slot allocator: watches both channels, predicts grants, compares.
`timescale 1ns / 1ps

module pooled_slot_allocator_chk
    import psa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire logic i_req_ready,
    input  wire t_req i_req,
    input  wire logic i_rsp_valid,
    input  wire logic i_rsp_ready,
    input  wire t_rsp i_rsp,
    output int        o_outstanding,
    output int        o_errors
);

    localparam int POOLS      = NUM_POOLS_DEF;
    localparam int SLOTS      = SLOTS_PER_POOL_DEF;
    localparam int MAX_PRINTS = 40;

    // Shadow copy of the per-pool stores
    logic [31:0]       slot_busy  [POOLS];
    logic [CNT_W-1:0]  slots_used [POOLS];
    logic [TAG_W-1:0]  owned_tag  [POOLS];
    logic [ID_W-1:0]   owned_by   [POOLS];

    // Grants predicted for accepted requests, oldest first
    t_rsp pending_grants[$];
    int   mismatch_count = 0;

    initial o_outstanding = 0;
    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
    endtask

    // Lowest clear bit among the usable slots, -1 when the pool has none
    function automatic int lowest_open_slot(input logic [31:0] busy);
        for (int s = 0; s < SLOTS && s < 32; s++) begin
            if (!busy[s])
                return s;
        end
        return -1;
    endfunction

    // Mark a slot taken and build the grant
    function automatic t_rsp take_slot(input int p, input int s);
        t_rsp rsp;
        slot_busy[p][s] = 1'b1;
        slots_used[p]   = slots_used[p] + CNT_W'(1);
        rsp.granted     = 1'b1;
        rsp.pool_index  = p[IDX_W-1:0];
        rsp.slot_index  = s[IDX_W-1:0];
        return rsp;
    endfunction

    // Predict one allocation and update the shadow stores
    function automatic t_rsp allocate_slot(input t_req r);
        int s;
        // existing pool of this owner and tag with room
        for (int p = 0; p < POOLS; p++) begin
            if (owned_by[p] == r.owner_id && owned_tag[p] == r.tag
                    && slots_used[p] < SLOTS) begin
                s = lowest_open_slot(slot_busy[p]);
                if (s >= 0)
                    return take_slot(p, s);
                break;
            end
        end
        // claim the first empty pool; the last pool is never claimed
        for (int p = 0; p < POOLS - 1; p++) begin
            if (slots_used[p] == '0) begin
                s = lowest_open_slot(slot_busy[p]);
                if (s >= 0) begin
                    owned_tag[p] = r.tag;
                    owned_by[p]  = r.owner_id;
                    return take_slot(p, s);
                end
                break;
            end
        end
        return '0;
    endfunction

    // Channel monitor: predict on request transfer, compare on response transfer
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int p = 0; p < POOLS; p++) begin
                slot_busy[p]  = '0;
                slots_used[p] = '0;
                owned_tag[p]  = '0;
                owned_by[p]   = '0;
            end
            pending_grants.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                pending_grants.push_back(allocate_slot(i_req));
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_grants.size() == 0) begin
                    report_mismatch("unexpected response", int'(i_rsp), 0);
                end else begin
                    want = pending_grants.pop_front();
                    if (i_rsp.granted !== want.granted)
                        report_mismatch("granted", int'(i_rsp.granted),
                                        int'(want.granted));
                    if (i_rsp.pool_index !== want.pool_index)
                        report_mismatch("pool_index", int'(i_rsp.pool_index),
                                        int'(want.pool_index));
                    if (i_rsp.slot_index !== want.slot_index)
                        report_mismatch("slot_index", int'(i_rsp.slot_index),
                                        int'(want.slot_index));
                end
            end
        end
        o_outstanding <= pending_grants.size();
    end

endmodule

[sim/pooled_slot_allocator_tb.sv]
// Testbench top for the pooled slot allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module pooled_slot_allocator_tb;
    import psa_pkg::*;

    localparam int POOLS        = NUM_POOLS_DEF;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PAIRS        = 8;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    t_req req_data  = '0;
    logic req_ready;
    logic rsp_valid;
    t_rsp rsp_data;
    int   errors;
    int   outstanding;

    // sender burst state and receiver stall pattern state
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    pooled_slot_allocator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_req   (req_data),
        .o_valid (rsp_valid),
        .i_ready (rsp_ready),
        .o_rsp   (rsp_data)
    );

    pooled_slot_allocator_chk u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req_data),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp_data),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: segments of always-ready, coin-flip and mostly-stalled
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= int'($urandom_range(0, 2));
            stall_left <= int'($urandom_range(10, 150));
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                rsp_ready <= 1'b1;
            end
            1: begin
                rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                rsp_ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // One request transfer, with a random gap whenever a burst runs out
    task automatic offer_req(input logic [ID_W-1:0] owner, input logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= t_req'{owner_id: owner, tag: tag};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Hold the sender until every predicted grant has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        logic [ID_W-1:0]  pair_owner [PAIRS];
        logic [TAG_W-1:0] pair_tag   [PAIRS];
        logic [ID_W-1:0]  owner;
        logic [TAG_W-1:0] tag;
        int pick;
        int k;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fresh-state match on pool 0, field extremes, near misses
        offer_req(16'h0000, 16'h0000);
        offer_req(16'h0000, 16'h0000);
        offer_req(16'hFFFF, 16'h8000);
        offer_req(16'hFFFF, 16'h7FFF);
        offer_req(16'hFFFF, 16'h8000);
        offer_req(16'h0000, 16'h0001);
        offer_req(16'h0001, 16'h0000);
        offer_req(16'h1234, 16'hFFFF);
        offer_req(16'h8000, 16'h8000);
        offer_req(16'h7FFF, 16'h7FFF);
        offer_req(16'hAAAA, 16'h5555);
        offer_req(16'h5555, 16'hAAAA);
        offer_req(16'h0000, 16'h0000);
        wait_drained();

        // A few recurring owner/tag pairs fill pools, claim new ones and
        // finally exhaust them; the zero pair walks into the last pool.
        pair_owner[0] = '0;
        pair_tag[0]   = '0;
        for (int i = 1; i < PAIRS; i++) begin
            pair_owner[i] = ID_W'($urandom);
            pair_tag[i]   = TAG_W'($urandom);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, PAIRS - 1);
            owner = pair_owner[k];
            tag   = pair_tag[k];
            if (pick >= 97) begin
                owner = ID_W'($urandom);
                tag   = TAG_W'($urandom);
            end else if (pick >= 92) begin
                // broken pair: one bit off in owner or tag
                if ($urandom_range(0, 1))
                    owner[$urandom_range(0, ID_W - 1)] ^= 1'b1;
                else
                    tag[$urandom_range(0, TAG_W - 1)] ^= 1'b1;
            end
            offer_req(owner, tag);
            if (n == 500 || n == 1000)
                wait_drained();
        end

        wait_drained();
        repeat (2 * (POOLS + 2)) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("pooled_slot_allocator_tb: done, clean");
        end else begin
            $display("pooled_slot_allocator_tb: done, errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("pooled_slot_allocator_tb: done, errors");
        $finish;
    end

endmodule
